FILE: rtl/core/tccc_pkg.sv
// shared types and constants for the text console cursor control core
// no dependencies
package tccc_pkg;

  localparam int ROW_W = 7;
  localparam int COL_W = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [ROW_W-1:0] ROW_COUNT_RESET = 7'd30;
  localparam logic [COL_W-1:0] COL_COUNT_RESET = 8'd80;

  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd1;

  localparam logic [1:0] CMD_DRAW   = 2'd0;
  localparam logic [1:0] CMD_SCROLL = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_CURSOR = 2'd3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_RIGHT = 1'b1;

  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_FORMFEED  = 8'd12;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  typedef struct packed {
    logic load;
    logic clamp;
    logic step;
    logic emit_scroll;
  } ctl_t;

  typedef struct packed {
    logic out_free;
    logic scroll_next;
    logic more;
  } sts_t;

endpackage

FILE: rtl/core/tccc_ctrl.sv
// sequencer for the console core: input handshake and result sequencing
// depends on tccc_pkg
module tccc_ctrl
  import tccc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output ctl_t ctl
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CLAMP  = 2'd1;
  localparam logic [1:0] S_STEP   = 2'd2;
  localparam logic [1:0] S_SCROLL = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    ctl = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load = 1'b1;
          state_next = S_CLAMP;
        end
      end
      S_CLAMP: begin
        ctl.clamp = 1'b1;
        state_next = S_STEP;
      end
      S_STEP: begin
        if (sts.out_free) begin
          ctl.step = 1'b1;
          if (sts.scroll_next) state_next = S_SCROLL;
          else if (sts.more) state_next = S_STEP;
          else state_next = S_IDLE;
        end
      end
      S_SCROLL: begin
        if (sts.out_free) begin
          ctl.emit_scroll = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign in_stall = (state != S_IDLE);

endmodule

FILE: rtl/core/tccc_dpath.sv
// datapath for the console core: screen size registers, cursor, step logic, result register
// depends on tccc_pkg
module tccc_dpath
  import tccc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  ctl_t                  ctl,
  output sts_t                  sts,
  input  logic                  operation,
  input  logic [7:0]            char_code,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            command,
  output logic [7:0]            glyph,
  output logic [ROW_W-1:0]      draw_row,
  output logic [COL_W-1:0]      draw_col,
  output logic [ROW_W-1:0]      cursor_row_after,
  output logic [COL_W-1:0]      cursor_col_after,
  output logic                  last
);

  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;
  logic [ROW_W-1:0] cur_row;
  logic [COL_W-1:0] cur_col;
  logic             op_r;
  logic [7:0]       char_r;
  logic [COL_W:0]   target;

  logic [COL_W-1:0] cols;
  logic [ROW_W-1:0] rows;
  logic [COL_W-1:0] cols_m1;
  logic [ROW_W-1:0] rows_m1;
  logic [ROW_W-1:0] clamp_row;
  logic [COL_W-1:0] clamp_col;
  logic             wrap;
  logic             bottom;
  logic             is_tab;
  logic             scrolled;
  logic [ROW_W-1:0] row_next;
  logic [COL_W-1:0] col_next;
  logic [1:0]       cmd_next;
  logic [7:0]       glyph_next;
  logic [ROW_W-1:0] drow_next;
  logic [COL_W-1:0] dcol_next;
  logic             last_next;
  logic             more;

  assign cols = (col_count == '0) ? COL_W'(1) : col_count;
  assign rows = (row_count == '0) ? ROW_W'(1) : row_count;
  assign cols_m1 = cols - COL_W'(1);
  assign rows_m1 = rows - ROW_W'(1);
  assign clamp_row = (cur_row >= rows) ? rows_m1 : cur_row;
  assign clamp_col = (cur_col >= cols) ? cols_m1 : cur_col;

  assign wrap = (cur_col >= cols_m1);
  assign bottom = (cur_row >= rows_m1);
  assign is_tab = (op_r == OP_WRITE) && (char_r == CH_TAB);

  always_comb begin
    row_next = cur_row;
    col_next = cur_col;
    cmd_next = CMD_CURSOR;
    glyph_next = '0;
    drow_next = '0;
    dcol_next = '0;
    scrolled = 1'b0;
    if (op_r == OP_RIGHT) begin
      if (!(cur_row == rows_m1 && cur_col == cols_m1)) begin
        if (wrap) begin
          col_next = '0;
          row_next = cur_row + ROW_W'(1);
        end else begin
          col_next = cur_col + COL_W'(1);
        end
      end
    end else begin
      case (char_r)
        CH_NEWLINE: begin
          col_next = '0;
          if (bottom) cmd_next = CMD_SCROLL;
          else row_next = cur_row + ROW_W'(1);
        end
        CH_BACKSPACE: begin
          if (cur_col != '0) begin
            col_next = cur_col - COL_W'(1);
          end else if (cur_row != '0) begin
            row_next = cur_row - ROW_W'(1);
            col_next = cols_m1;
          end
        end
        CH_FORMFEED: begin
          row_next = '0;
          col_next = '0;
          cmd_next = CMD_CLEAR;
        end
        default: begin
          cmd_next = CMD_DRAW;
          glyph_next = is_tab ? CH_SPACE : char_r;
          drow_next = cur_row;
          dcol_next = cur_col;
          if (wrap) begin
            col_next = '0;
            if (bottom) begin
              row_next = rows_m1;
              scrolled = 1'b1;
            end else begin
              row_next = cur_row + ROW_W'(1);
            end
          end else begin
            col_next = cur_col + COL_W'(1);
          end
        end
      endcase
    end
  end

  assign more = is_tab && !scrolled && (col_next != '0) && ({1'b0, col_next} < target);
  assign last_next = !scrolled && !more;

  assign sts.out_free = !out_valid || !out_stall;
  assign sts.scroll_next = scrolled;
  assign sts.more = more;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= COL_COUNT_RESET;
      row_count <= ROW_COUNT_RESET;
      cur_row <= '0;
      cur_col <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_COL_COUNT) col_count <= cfg_data[COL_W-1:0];
        else if (cfg_index == REG_ROW_COUNT) row_count <= cfg_data[ROW_W-1:0];
      end
      if (ctl.clamp) begin
        cur_row <= clamp_row;
        cur_col <= clamp_col;
      end else if (ctl.step) begin
        cur_row <= row_next;
        cur_col <= col_next;
      end
      if (ctl.step || ctl.emit_scroll) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_r <= operation;
      char_r <= char_code;
    end
    if (ctl.clamp) target <= {({1'b0, clamp_col[COL_W-1:3]} + 6'd1), 3'b000};
    if (ctl.step) begin
      command <= cmd_next;
      glyph <= glyph_next;
      draw_row <= drow_next;
      draw_col <= dcol_next;
      cursor_row_after <= row_next;
      cursor_col_after <= col_next;
      last <= last_next;
    end else if (ctl.emit_scroll) begin
      command <= CMD_SCROLL;
      glyph <= '0;
      draw_row <= '0;
      draw_col <= '0;
      cursor_row_after <= cur_row;
      cursor_col_after <= cur_col;
      last <= 1'b1;
    end
  end

endmodule

FILE: rtl/core/text_console_cursor_control_core.sv
// top level of the text console cursor control core
// depends on tccc_pkg, tccc_ctrl, tccc_dpath
// a taken word is loaded, the cursor clamped, then n registered results (n = 1..9) issue,
//   one per cycle from the shared step unit unless the output stalls; a word is taken
//   only after its previous word has issued all results
// reset: synchronous; cursor at home, 80 columns, 30 rows, no result pending
module text_console_cursor_control_core
  import tccc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  operation,
  input  logic [7:0]            char_code,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            command,
  output logic [7:0]            glyph,
  output logic [ROW_W-1:0]      draw_row,
  output logic [COL_W-1:0]      draw_col,
  output logic [ROW_W-1:0]      cursor_row_after,
  output logic [COL_W-1:0]      cursor_col_after,
  output logic                  last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctl_t ctl;
  sts_t sts;

  assign cfg_ready = 1'b1;

  tccc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  tccc_dpath u_dpath (
    .clk              (clk),
    .rst              (rst),
    .ctl              (ctl),
    .sts              (sts),
    .operation        (operation),
    .char_code        (char_code),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .command          (command),
    .glyph            (glyph),
    .draw_row         (draw_row),
    .draw_col         (draw_col),
    .cursor_row_after (cursor_row_after),
    .cursor_col_after (cursor_col_after),
    .last             (last)
  );

endmodule
